// ----- hdl/dhsp_pkg.sv -----
// shared types and constants of the header stream parser
package dhsp_pkg;

   localparam int PosWidth    = 28;
   localparam int QueueDepth  = 4;
   localparam int QueuePtrW   = $clog2(QueueDepth);

   localparam logic [1:0] KindText    = 2'd0;
   localparam logic [1:0] KindSummary = 2'd1;
   localparam logic [1:0] KindError   = 2'd2;

   localparam logic [2:0] ErrTrunc   = 3'd0;
   localparam logic [2:0] ErrShort   = 3'd1;
   localparam logic [2:0] ErrOverrun = 3'd2;
   localparam logic [2:0] ErrVariant = 3'd3;
   localparam logic [2:0] ErrCode    = 3'd4;

   localparam logic [3:0] FieldNone        = 4'd0;
   localparam logic [3:0] FieldPath        = 4'd1;
   localparam logic [3:0] FieldInterface   = 4'd2;
   localparam logic [3:0] FieldMember      = 4'd3;
   localparam logic [3:0] FieldErrorName   = 4'd4;
   localparam logic [3:0] FieldReplySerial = 4'd5;
   localparam logic [3:0] FieldDestination = 4'd6;
   localparam logic [3:0] FieldSender      = 4'd7;
   localparam logic [3:0] FieldSignature   = 4'd8;
   localparam logic [3:0] FieldUnixFds     = 4'd9;
   localparam logic [3:0] FieldLastKnown   = 4'd9;
   localparam logic [3:0] FieldUnknown     = 4'd15;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [3:0]  field_code;
      logic [7:0]  text_byte;
      logic [7:0]  endian_mark;
      logic [7:0]  message_type;
      logic [7:0]  header_flags;
      logic [7:0]  protocol_version;
      logic [31:0] body_length;
      logic [31:0] message_serial;
      logic [31:0] reply_to_serial;
      logic [31:0] fd_count;
      logic [2:0]  error_code;
   } result_type;

endpackage

// ----- hdl/dhsp_if.sv -----
// item channels of the header stream parser
interface dhsp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  message_byte;
   logic        start_of_message;
   logic [27:0] message_length;
   modport source (output valid, message_byte, start_of_message, message_length, input ready);
   modport sink (input valid, message_byte, start_of_message, message_length, output ready);
endinterface

interface dhsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [3:0]  field_code;
   logic [7:0]  text_byte;
   logic [7:0]  endian_mark;
   logic [7:0]  message_type;
   logic [7:0]  header_flags;
   logic [7:0]  protocol_version;
   logic [31:0] body_length;
   logic [31:0] message_serial;
   logic [31:0] reply_to_serial;
   logic [31:0] fd_count;
   logic [2:0]  error_code;
   modport source (output valid, result_kind, field_code, text_byte, endian_mark,
                   message_type, header_flags, protocol_version, body_length,
                   message_serial, reply_to_serial, fd_count, error_code,
                   input ready);
   modport sink (input valid, result_kind, field_code, text_byte, endian_mark,
                 message_type, header_flags, protocol_version, body_length,
                 message_serial, reply_to_serial, fd_count, error_code,
                 output ready);
endinterface

// ----- hdl/dhsp_front.sv -----
// byte parser: fixed header capture, field array walk, result generation
module dhsp_front #(
   parameter logic [31:0] MAX_MESSAGE_BYTES = 32'd134217728
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           message_byte,
   input  logic                 start_of_message,
   input  logic [27:0]          message_length,
   output logic                 push,
   output dhsp_pkg::result_type push_data
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_FIXED, PH_CODE, PH_SIGLEN, PH_SIGBODY,
      PH_STRLEN, PH_TEXT, PH_SIGVLEN, PH_WORD
   } phase_type;

   phase_type        phase_ff, phase_in, ph;
   logic [27:0]      pos_ff, pos_in, pos_now, noff, len_cl;
   logic [15:0][7:0] hdr_ff, hdr_in;
   logic [31:0]      arr_ff, arr_in, arr_new, arr_src, body_new;
   logic [32:0]      region_ff, region_in, region_new, region_src;
   logic [3:0]       field_ff, field_in;
   logic [31:0]      left_ff, left_in;
   logic [31:0]      word_ff, word_in, wn;
   logic [31:0]      reply_ff, reply_in, fd_ff, fd_in;
   logic [28:0]      a29;
   logic             nf_done, nf_over, do_next, do_err, short_hit;
   logic [31:0]      nf_left;
   logic [2:0]       err_code, le;
   logic [1:0]       k, pad;
   logic [33:0]      region34, sum1, sumb, sump, sumw;

   always_comb begin
      len_cl  = ({4'b0, message_length} > MAX_MESSAGE_BYTES) ?
                MAX_MESSAGE_BYTES[27:0] : message_length;
      pos_now = start_of_message ? 28'd0 : pos_ff + 28'd1;
      noff    = (pos_now >= 28'd15) ? pos_now - 28'd15 : 28'd0;
      ph      = start_of_message ? PH_FIXED : phase_ff;
      body_new   = hdr_ff[7:4];
      arr_new    = {message_byte, hdr_ff[14], hdr_ff[13], hdr_ff[12]};
      short_hit  = ({2'b0, body_new} + {2'b0, arr_new} + 34'd16) > {6'b0, len_cl};
      region_new = 33'({5'b0, len_cl} - {1'b0, body_new} - 33'd16);
      arr_src    = (ph == PH_FIXED) ? arr_new : arr_ff;
      region_src = (ph == PH_FIXED) ? region_new : region_ff;
      region34   = {1'b0, region_src};
      a29     = ({1'b0, noff} + 29'd7) & ~29'd7;
      nf_done = {3'b0, a29} >= arr_src;
      nf_over = ({5'b0, a29} + 34'd1) > region34;
      nf_left = 32'(a29 - {1'b0, noff}) + 32'd1;
      pad     = 2'(2'd0 - noff[1:0]);
      sum1    = {6'b0, noff} + 34'd1;
      sumb    = {6'b0, noff} + {26'b0, message_byte} + 34'd1;
      sump    = {6'b0, noff} + {32'b0, pad} + 34'd4;
      le      = (left_ff == 32'd0) ? 3'd1 : left_ff[2:0];
      k       = 2'(3'd4 - le);
      wn      = word_ff | ({24'b0, message_byte} << {k, 3'b000});
      sumw    = {6'b0, noff} + {2'b0, wn} + 34'd1;
   end

   always_comb begin
      pos_in = pos_ff; phase_in = phase_ff; hdr_in = hdr_ff; arr_in = arr_ff;
      region_in = region_ff; field_in = field_ff; left_in = left_ff;
      word_in = word_ff; reply_in = reply_ff; fd_in = fd_ff;
      do_next = 1'b0; do_err = 1'b0; err_code = dhsp_pkg::ErrTrunc;
      push = 1'b0; push_data = '0;
      if (fire) begin
         pos_in = pos_now;
         if (start_of_message) begin
            phase_in = PH_FIXED; arr_in = '0; region_in = '0; field_in = '0;
            left_in = '0; word_in = '0; reply_in = '0; fd_in = '0;
         end
         if (start_of_message && len_cl < 28'd16) begin
            do_err = 1'b1;
            err_code = dhsp_pkg::ErrTrunc;
         end else begin
            unique case (ph)
               PH_FIXED: begin
                  hdr_in[pos_now[3:0]] = message_byte;
                  if (pos_now[3:0] == 4'hF) begin
                     if (short_hit) begin
                        do_err = 1'b1;
                        err_code = dhsp_pkg::ErrShort;
                     end else begin
                        region_in = region_new;
                        arr_in = arr_new;
                        do_next = 1'b1;
                     end
                  end
               end
               PH_CODE: begin
                  if (left_ff > 32'd1) begin
                     left_in = left_ff - 32'd1;
                  end else begin
                     left_in = '0;
                     field_in = (message_byte <= 8'(dhsp_pkg::FieldLastKnown)) ?
                                message_byte[3:0] : dhsp_pkg::FieldUnknown;
                     if (sum1 > region34) begin
                        do_err = 1'b1;
                        err_code = dhsp_pkg::ErrOverrun;
                     end else begin
                        phase_in = PH_SIGLEN;
                     end
                  end
               end
               PH_SIGLEN: begin
                  if (sumb > region34) begin
                     do_err = 1'b1;
                     err_code = dhsp_pkg::ErrOverrun;
                  end else if (message_byte != 8'd1) begin
                     do_err = 1'b1;
                     err_code = dhsp_pkg::ErrVariant;
                  end else begin
                     phase_in = PH_SIGBODY;
                     left_in = 32'd2;
                  end
               end
               PH_SIGBODY: begin
                  if (left_ff > 32'd1) begin
                     left_in = left_ff - 32'd1;
                  end else begin
                     left_in = '0;
                     unique case (field_ff) inside
                        dhsp_pkg::FieldPath, dhsp_pkg::FieldInterface,
                        dhsp_pkg::FieldMember, dhsp_pkg::FieldErrorName,
                        dhsp_pkg::FieldReplySerial, dhsp_pkg::FieldDestination,
                        dhsp_pkg::FieldSender, dhsp_pkg::FieldUnixFds: begin
                           if (sump > region34) begin
                              do_err = 1'b1;
                              err_code = dhsp_pkg::ErrOverrun;
                           end else begin
                              phase_in = (field_ff == dhsp_pkg::FieldReplySerial ||
                                          field_ff == dhsp_pkg::FieldUnixFds) ?
                                         PH_WORD : PH_STRLEN;
                              left_in = {30'b0, pad} + 32'd4;
                              word_in = '0;
                           end
                        end
                        dhsp_pkg::FieldSignature: begin
                           if (sum1 > region34) begin
                              do_err = 1'b1;
                              err_code = dhsp_pkg::ErrOverrun;
                           end else begin
                              phase_in = PH_SIGVLEN;
                           end
                        end
                        default: begin
                           do_err = 1'b1;
                           err_code = dhsp_pkg::ErrCode;
                        end
                     endcase
                  end
               end
               PH_STRLEN, PH_WORD: begin
                  if (left_ff > 32'd4) begin
                     left_in = left_ff - 32'd1;
                  end else begin
                     word_in = wn;
                     left_in = {29'b0, le} - 32'd1;
                     if (le == 3'd1) begin
                        if (ph == PH_WORD) begin
                           if (field_ff == dhsp_pkg::FieldReplySerial) begin
                              reply_in = wn;
                           end else begin
                              fd_in = wn;
                           end
                           do_next = 1'b1;
                        end else if (sumw > region34) begin
                           do_err = 1'b1;
                           err_code = dhsp_pkg::ErrOverrun;
                        end else begin
                           phase_in = PH_TEXT;
                           left_in = wn + 32'd1;
                        end
                     end
                  end
               end
               PH_SIGVLEN: begin
                  if (sumb > region34) begin
                     do_err = 1'b1;
                     err_code = dhsp_pkg::ErrOverrun;
                  end else begin
                     phase_in = PH_TEXT;
                     left_in = {24'b0, message_byte} + 32'd1;
                  end
               end
               PH_TEXT: begin
                  if (left_ff > 32'd1) begin
                     left_in = left_ff - 32'd1;
                     push = 1'b1;
                     push_data.result_kind = dhsp_pkg::KindText;
                     push_data.field_code = field_ff;
                     push_data.text_byte = message_byte;
                  end else begin
                     left_in = '0;
                     do_next = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (do_next) begin
            if (nf_done) begin
               push = 1'b1;
               phase_in = PH_IDLE;
               push_data.result_kind = dhsp_pkg::KindSummary;
               push_data.endian_mark = hdr_in[0];
               push_data.message_type = hdr_in[1];
               push_data.header_flags = hdr_in[2];
               push_data.protocol_version = hdr_in[3];
               push_data.body_length = hdr_in[7:4];
               push_data.message_serial = hdr_in[11:8];
               push_data.reply_to_serial = reply_in;
               push_data.fd_count = fd_in;
            end else if (nf_over) begin
               do_err = 1'b1;
               err_code = dhsp_pkg::ErrOverrun;
            end else begin
               phase_in = PH_CODE;
               left_in = nf_left;
            end
         end
         if (do_err) begin
            push = 1'b1;
            phase_in = PH_IDLE;
            push_data.result_kind = dhsp_pkg::KindError;
            push_data.error_code = err_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff <= '0;
         arr_ff <= '0;
         region_ff <= '0;
         field_ff <= '0;
         left_ff <= '0;
         word_ff <= '0;
         reply_ff <= '0;
         fd_ff <= '0;
         hdr_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         arr_ff <= arr_in;
         region_ff <= region_in;
         field_ff <= field_in;
         left_ff <= left_in;
         word_ff <= word_in;
         reply_ff <= reply_in;
         fd_ff <= fd_in;
         hdr_ff <= hdr_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> fire)
      else $error("result without accepted item");
   assert property (@(posedge clock) disable iff (reset)
      (push && push_data.result_kind != dhsp_pkg::KindText) |=> phase_ff == PH_IDLE)
      else $error("parse not ended after summary or error");
   assert property (@(posedge clock) disable iff (reset)
      (push && push_data.result_kind == dhsp_pkg::KindText) |->
      (phase_ff == PH_TEXT && !start_of_message))
      else $error("text item outside text phase");
   assert property (@(posedge clock) disable iff (reset)
      (fire && !start_of_message) |=> pos_ff == 28'($past(pos_ff) + 28'd1))
      else $error("byte position not advanced");

endmodule

// ----- hdl/dhsp_queue.sv -----
// short result queue between parser and output stage
module dhsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dhsp_pkg::result_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 avail,
   output dhsp_pkg::result_type pop_data
);

   dhsp_pkg::result_type             mem [dhsp_pkg::QueueDepth];
   logic [dhsp_pkg::QueuePtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [dhsp_pkg::QueuePtrW:0]     count_ff, count_in;

   always_comb begin
      full  = count_ff == (dhsp_pkg::QueuePtrW + 1)'(dhsp_pkg::QueueDepth);
      avail = count_ff != '0;
      pop_data = mem[rd_ff];
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + {{dhsp_pkg::QueuePtrW{1'b0}}, push}
                 - {{dhsp_pkg::QueuePtrW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> avail)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (dhsp_pkg::QueuePtrW + 1)'(dhsp_pkg::QueueDepth))
      else $error("queue count out of range");

endmodule

// ----- hdl/dhsp_back.sv -----
// output stage: takes results from the queue into the result register
module dhsp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 avail,
   input  dhsp_pkg::result_type pop_data,
   output logic                 pop,
   dhsp_rsp_if.source           rsp_chan
);

   logic                 valid_ff, valid_in;
   dhsp_pkg::result_type data_ff, data_in;

   always_comb begin
      pop = avail && (!valid_ff || rsp_chan.ready);
      valid_in = pop ? 1'b1 : (valid_ff && !rsp_chan.ready);
      data_in = pop ? pop_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.result_kind      = data_ff.result_kind;
   assign rsp_chan.field_code       = data_ff.field_code;
   assign rsp_chan.text_byte        = data_ff.text_byte;
   assign rsp_chan.endian_mark      = data_ff.endian_mark;
   assign rsp_chan.message_type     = data_ff.message_type;
   assign rsp_chan.header_flags     = data_ff.header_flags;
   assign rsp_chan.protocol_version = data_ff.protocol_version;
   assign rsp_chan.body_length      = data_ff.body_length;
   assign rsp_chan.message_serial   = data_ff.message_serial;
   assign rsp_chan.reply_to_serial  = data_ff.reply_to_serial;
   assign rsp_chan.fd_count         = data_ff.fd_count;
   assign rsp_chan.error_code       = data_ff.error_code;

endmodule

// ----- hdl/dbus_header_stream_parser.sv -----
// top level of the message header stream parser
// throughput: one byte item per cycle while the result side keeps up
// a result reaches rsp_chan through the queue and then the output register
// the parser decides on each accepted byte combinationally; a four-entry queue and the
// output register absorb result-side stalls before req_chan.ready drops
// reset: synchronous, active high; parser idle, queue and output empty
module dbus_header_stream_parser #(
   parameter logic [31:0] MAX_MESSAGE_BYTES = 32'd134217728
) (
   input  logic       clock,
   input  logic       reset,
   dhsp_req_if.sink   req_chan,
   dhsp_rsp_if.source rsp_chan
);

   logic                 fire, push, full, pop, avail;
   dhsp_pkg::result_type push_data, pop_data;

   assign req_chan.ready = !full;
   assign fire = req_chan.valid && !full;

   dhsp_front #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_front (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .message_byte(req_chan.message_byte),
      .start_of_message(req_chan.start_of_message),
      .message_length(req_chan.message_length),
      .push(push),
      .push_data(push_data)
   );

   dhsp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .full(full),
      .pop(pop),
      .avail(avail),
      .pop_data(pop_data)
   );

   dhsp_back u_back (
      .clock(clock),
      .reset(reset),
      .avail(avail),
      .pop_data(pop_data),
      .pop(pop),
      .rsp_chan(rsp_chan)
   );

endmodule
